// ===== design/ubxr_pkg.sv =====
// Package for the binary frame receiver: phase codes, constants and the per-byte result type.
package ubxr_pkg;

    // Sync pair and framing constants
    localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND  = 8'h62;
    localparam logic [15:0] LENGTH_EXTRA = 16'd4;
    localparam logic [15:0] LIMIT_RESET  = 16'd150;

    // Receive phase
    typedef enum logic [1:0] {
        PH_HUNT     = 2'd0,
        PH_HEADER   = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_CHECKSUM = 2'd3
    } phase_t;

    // One result item, as produced for each received byte
    typedef struct packed {
        logic [7:0]  byte_data;
        logic        byte_in_frame;
        logic [16:0] byte_index;
        logic        frame_done;
        logic [15:0] frame_length;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
    } result_t;

endpackage

// ===== design/ubxr_parser.sv =====
// Frame parser: per-byte state update (sync hunt, header, payload, Fletcher-8 check).
module ubxr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [15:0]      length_limit,
    output ubxr_pkg::result_t res
);
    import ubxr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_low_reg, len_low_next;

    logic [16:0] cnt_inc;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] new_len;

    // Next state and result for the byte on rx_byte
    always_comb
    begin
        cnt_inc = byte_count_reg + 17'd1;
        acc_a   = sum_a_reg + rx_byte;
        acc_b   = sum_b_reg + acc_a;
        new_len = {rx_byte, len_low_reg} + LENGTH_EXTRA;

        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        frame_len_next  = frame_len_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        class_next      = class_reg;
        id_next         = id_reg;
        len_low_next    = len_low_reg;

        res               = '0;
        res.byte_data     = rx_byte;

        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_count_reg == 17'd0)
                begin
                    if (rx_byte == SYNC_FIRST)
                        byte_count_next = 17'd1;
                end
                else
                begin
                    byte_count_next = 17'd0;
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_HEADER;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                        class_next = 8'd0;
                        id_next    = 8'd0;
                    end
                end
            end
            PH_HEADER:
            begin
                byte_count_next = cnt_inc;
                sum_a_next      = acc_a;
                sum_b_next      = acc_b;
                case (byte_count_reg[1:0])
                    2'd0: class_next   = rx_byte;
                    2'd1: id_next      = rx_byte;
                    2'd2: len_low_next = rx_byte;
                    default:
                    begin
                        frame_len_next = new_len;
                        if (new_len > LENGTH_EXTRA && new_len < length_limit)
                            phase_next = PH_PAYLOAD;
                        else
                        begin
                            phase_next      = PH_HUNT;
                            byte_count_next = 17'd0;
                        end
                    end
                endcase
            end
            PH_PAYLOAD:
            begin
                byte_count_next = cnt_inc;
                sum_a_next      = acc_a;
                sum_b_next      = acc_b;
                if (cnt_inc == {1'b0, frame_len_reg})
                    phase_next = PH_CHECKSUM;
            end
            default:
            begin
                // Checksum bytes: first against sum A, second against sum B
                byte_count_next = cnt_inc;
                if (cnt_inc == {1'b0, frame_len_reg} + 17'd1)
                begin
                    if (rx_byte != sum_a_reg)
                    begin
                        phase_next      = PH_HUNT;
                        byte_count_next = 17'd0;
                    end
                end
                else
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = 17'd0;
                    if (rx_byte == sum_b_reg)
                    begin
                        res.frame_done   = 1'b1;
                        res.frame_length = frame_len_reg;
                    end
                end
            end
        endcase

        if (phase_reg != PH_HUNT)
        begin
            res.byte_in_frame = 1'b1;
            res.byte_index    = byte_count_reg;
            res.msg_class     = class_next;
            res.msg_id        = id_next;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= 17'd0;
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            class_reg      <= 8'd0;
            id_reg         <= 8'd0;
            len_low_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            class_reg      <= class_next;
            id_reg         <= id_next;
            len_low_reg    <= len_low_next;
        end
    end

    // Frame length: written by the second length byte before any read
    always_ff @(posedge clk)
    begin
        if (step)
            frame_len_reg <= frame_len_next;
    end

    // Checks
    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> byte_count_reg[16:1] == 16'd0)
        else $error("sync hunt count out of range");

    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> byte_count_reg[16:2] == 15'd0)
        else $error("header count beyond length bytes");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD || phase_reg == PH_CHECKSUM) |-> frame_len_reg > LENGTH_EXTRA)
        else $error("payload phase with a short frame length");

    a_done_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        res.frame_done |-> phase_reg == PH_CHECKSUM)
        else $error("frame done outside checksum phase");

endmodule

// ===== design/ubx_frame_receiver.sv =====
// Top level of the binary frame receiver: handshakes, limit register and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  input    | in_valid / in_ready    | rx_byte
//  result   | out_valid / out_ready  | byte_data, byte_in_frame, byte_index,
//           |                        | frame_done, frame_length, msg_class, msg_id
//  config   | cfg_we                 | cfg_wdata (length_limit)
//
// One byte per clock unless the output stalls: the parser state updates at the
// accepting edge and the result is in the result register from the next cycle.
// in_ready is high while the result register is empty or being taken, so a
// stalled output holds one result and pauses the input only after that.
// Reset clears the parser to sync hunt and sets the limit to 150.
module ubx_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_data,
    output logic        byte_in_frame,
    output logic [16:0] byte_index,
    output logic        frame_done,
    output logic [15:0] frame_length,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id
);
    import ubxr_pkg::*;

    logic [15:0] length_limit_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;
    result_t     res;
    logic        step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // Parser
    ubxr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (rx_byte),
        .length_limit (length_limit_reg),
        .res          (res)
    );

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_limit_reg <= LIMIT_RESET;
        else if (cfg_we)
            length_limit_reg <= cfg_wdata;
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign byte_data     = res_reg.byte_data;
    assign byte_in_frame = res_reg.byte_in_frame;
    assign byte_index    = res_reg.byte_index;
    assign frame_done    = res_reg.frame_done;
    assign frame_length  = res_reg.frame_length;
    assign msg_class     = res_reg.msg_class;
    assign msg_id        = res_reg.msg_id;

    // Checks
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted item left no result");

    a_done_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> byte_in_frame && frame_length != 16'd0)
        else $error("frame done without a frame");

    a_hunt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_in_frame |-> byte_index == 17'd0 && msg_class == 8'd0
            && msg_id == 8'd0)
        else $error("sync hunt byte carries frame fields");

endmodule

// ===== verif/tb_ubx_frame_receiver.sv =====
// Testbench for ubx_frame_receiver: frame traffic with stalls, checked against a local parser.
module tb_ubx_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import ubxr_pkg::*;

    // Header byte positions, counted from the class byte
    localparam logic [16:0] POS_CLASS  = 17'd0;
    localparam logic [16:0] POS_ID     = 17'd1;
    localparam logic [16:0] POS_LEN_LO = 17'd2;

    localparam logic [15:0] LIMIT_MIN = 16'd5;
    localparam logic [15:0] LIMIT_MAX = 16'd65535;

    typedef enum int { CK_GOOD, CK_BAD_A, CK_BAD_B } ck_fault_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  byte_data;
    logic        byte_in_frame;
    logic [16:0] byte_index;
    logic        frame_done;
    logic [15:0] frame_length;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;

    // Parser state as the block should hold it
    phase_t      rx_ph       = PH_HUNT;
    logic [16:0] pos_cnt     = '0;
    logic [15:0] flen        = '0;
    logic [7:0]  fl_a        = '0;
    logic [7:0]  fl_b        = '0;
    logic [7:0]  cls_q       = '0;
    logic [7:0]  id_q        = '0;
    logic [7:0]  len_lo_q    = '0;
    logic [15:0] limit_q     = LIMIT_RESET;

    result_t     due_results[$];
    int unsigned mismatch_count   = 0;
    int unsigned frame_bytes_sent = 0;
    bit          no_gaps          = 1'b0;

    ubx_frame_receiver uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_data     (byte_data),
        .byte_in_frame (byte_in_frame),
        .byte_index    (byte_index),
        .frame_done    (frame_done),
        .frame_length  (frame_length),
        .msg_class     (msg_class),
        .msg_id        (msg_id)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Parse one byte: update the local state and return the result it gives
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t     r;
        logic [16:0] idx;
        r = '0;
        r.byte_data = b;
        if (rx_ph == PH_HUNT)
        begin
            if (pos_cnt == 17'd0)
            begin
                if (b == SYNC_FIRST)
                    pos_cnt = 17'd1;
            end
            else
            begin
                // anything but the second sync byte restarts the hunt
                pos_cnt = 17'd0;
                if (b == SYNC_SECOND)
                begin
                    rx_ph = PH_HEADER;
                    fl_a  = '0;
                    fl_b  = '0;
                    cls_q = '0;
                    id_q  = '0;
                end
            end
        end
        else
        begin
            idx = pos_cnt;
            r.byte_in_frame = 1'b1;
            r.byte_index    = idx;
            pos_cnt = pos_cnt + 17'd1;
            if (rx_ph != PH_CHECKSUM)
            begin
                fl_a = fl_a + b;
                fl_b = fl_b + fl_a;
            end
            case (rx_ph)
                PH_HEADER:
                begin
                    if (idx == POS_CLASS)
                        cls_q = b;
                    else if (idx == POS_ID)
                        id_q = b;
                    else if (idx == POS_LEN_LO)
                        len_lo_q = b;
                    else
                    begin
                        // length wraps mod 2^16 before the bounds test
                        flen = {b, len_lo_q} + LENGTH_EXTRA;
                        if (flen > LENGTH_EXTRA && flen < limit_q)
                            rx_ph = PH_PAYLOAD;
                        else
                        begin
                            rx_ph   = PH_HUNT;
                            pos_cnt = '0;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pos_cnt == {1'b0, flen})
                        rx_ph = PH_CHECKSUM;
                end
                default:
                begin
                    if (pos_cnt == {1'b0, flen} + 17'd1)
                    begin
                        if (b != fl_a)
                        begin
                            rx_ph   = PH_HUNT;
                            pos_cnt = '0;
                        end
                    end
                    else
                    begin
                        rx_ph   = PH_HUNT;
                        pos_cnt = '0;
                        if (b == fl_b)
                        begin
                            r.frame_done   = 1'b1;
                            r.frame_length = flen;
                        end
                    end
                end
            endcase
            r.msg_class = cls_q;
            r.msg_id    = id_q;
        end
        return r;
    endfunction

    // Offer one byte and wait for it to be taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (!no_gaps && $urandom_range(0, 99) < 7)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do @(posedge clk); while (!in_ready);
        due_results.push_back(parse_byte(b));
    endtask

    // Sync pair and header, then, unless hdr_only, the payload and the two checksum bytes
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] plen, input ck_fault_t fault,
                              input bit hdr_only);
        logic [7:0] hdr[4];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] d;
        hdr  = '{cls, id, plen[7:0], plen[15:8]};
        ck_a = '0;
        ck_b = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        foreach (hdr[i])
        begin
            send_byte(hdr[i]);
            ck_a = ck_a + hdr[i];
            ck_b = ck_b + ck_a;
        end
        if (!hdr_only)
        begin
            for (int i = 0; i < int'(plen); i++)
            begin
                d = 8'($urandom);
                send_byte(d);
                ck_a = ck_a + d;
                ck_b = ck_b + ck_a;
            end
            if (fault == CK_BAD_A)
                ck_a = ck_a ^ 8'($urandom_range(1, 255));
            if (fault == CK_BAD_B)
                ck_b = ck_b ^ 8'($urandom_range(1, 255));
            send_byte(ck_a);
            send_byte(ck_b);
        end
        frame_bytes_sent += 6 + (hdr_only ? 0 : int'(plen) + 2);
    endtask

    // Line noise, biased towards the sync bytes
    task automatic send_noise(input int unsigned n);
        int unsigned pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                send_byte(SYNC_FIRST);
            else if (pick == 1)
                send_byte(SYNC_SECOND);
            else
                send_byte(8'($urandom));
        end
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we  = 1'b0;
        limit_q = value;
    endtask

    // Hunt behaviour: noise, repeated first sync byte, wrong second byte
    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_frame(8'h00, 8'hFF, 16'd1, CK_GOOD, 1'b0);
    endtask

    // Bounds at the reset limit, including lengths that wrap
    task automatic test_length_bounds();
        send_frame(8'hFF, 8'h00, LIMIT_RESET - LIMIT_MIN, CK_GOOD, 1'b0);
        send_frame(8'h12, 8'h34, LIMIT_RESET - LENGTH_EXTRA, CK_GOOD, 1'b1);
        send_frame(8'h01, 8'h02, 16'd0, CK_GOOD, 1'b1);
        send_frame(8'h03, 8'h04, 16'hFFFF, CK_GOOD, 1'b1);
        send_frame(8'h05, 8'h06, 16'hFFFC, CK_GOOD, 1'b1);
    endtask

    task automatic test_checksum_faults();
        send_frame(8'hA5, 8'h5A, 16'd3, CK_BAD_A, 1'b0);
        send_frame(8'h5A, 8'hA5, 16'd3, CK_BAD_B, 1'b0);
        send_frame(8'h0F, 8'hF0, 16'd2, CK_GOOD, 1'b0);
    endtask

    // Lowest limit rejects all; highest admits a frame above the reset limit
    // and still rejects a length equal to the highest limit
    task automatic test_limit_extremes();
        set_limit(LIMIT_MIN);
        send_frame(8'h10, 8'h20, 16'd1, CK_GOOD, 1'b0);
        set_limit(LIMIT_MAX);
        send_frame(8'h30, 8'h40, 16'd200, CK_GOOD, 1'b0);
        send_frame(8'h50, 8'h60, LIMIT_MAX - LENGTH_EXTRA, CK_GOOD, 1'b1);
    endtask

    // Mostly well-formed frames with random content, some faults and noise
    task automatic test_random_traffic();
        logic [15:0] lim[4];
        logic [15:0] plen;
        int unsigned quota;
        int unsigned pick;
        int unsigned cap;
        lim[0] = 16'($urandom_range(20, 300));
        lim[1] = LIMIT_MAX;
        lim[2] = 16'($urandom_range(6, 40));
        lim[3] = LIMIT_RESET;
        foreach (lim[p])
        begin
            set_limit(lim[p]);
            no_gaps = (p == 1);
            quota   = frame_bytes_sent + 160;
            while (frame_bytes_sent < quota)
            begin
                pick = $urandom_range(0, 99);
                cap  = int'(lim[p]) - 5;
                if (cap > 48 && $urandom_range(0, 9) != 0)
                    cap = 48;
                if (cap > 400)
                    cap = 400;
                plen = 16'($urandom_range(1, cap));
                if (pick < 70)
                    send_frame(8'($urandom), 8'($urandom), plen, CK_GOOD, 1'b0);
                else if (pick < 78)
                    send_frame(8'($urandom), 8'($urandom), plen, CK_BAD_A, 1'b0);
                else if (pick < 86)
                    send_frame(8'($urandom), 8'($urandom), plen, CK_BAD_B, 1'b0);
                else if (pick < 93)
                begin
                    // header aimed at failing the length test; at the highest limit some lengths wrap and pass
                    case ($urandom_range(0, 2))
                        0:       plen = lim[p] - LENGTH_EXTRA + 16'($urandom_range(0, 16));
                        1:       plen = 16'($urandom_range(16'hFFFC, 16'hFFFF));
                        default: plen = 16'd0;
                    endcase
                    send_frame(8'($urandom), 8'($urandom), plen, CK_GOOD, 1'b1);
                end
                else
                    send_noise($urandom_range(1, 6));
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random stalls, set at the falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = no_gaps || ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each taken result with the oldest expectation
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing expected: byte_data %0d", byte_data);
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("byte_data", want.byte_data, byte_data);
                    check_field("byte_in_frame", want.byte_in_frame, byte_in_frame);
                    check_field("byte_index", want.byte_index, byte_index);
                    check_field("frame_done", want.frame_done, frame_done);
                    check_field("frame_length", want.frame_length, frame_length);
                    check_field("msg_class", want.msg_class, msg_class);
                    check_field("msg_id", want.msg_id, msg_id);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_sync_hunt();
        test_length_bounds();
        test_checksum_faults();
        test_limit_extremes();
        test_random_traffic();

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("ubx_frame_receiver: match");
        else
            $display("ubx_frame_receiver: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("ubx_frame_receiver: mismatch");
        $finish;
    end

endmodule
